// ----- rtl/qslerp_pkg.sv -----
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared constants, tables and types of the quaternion slerp pipeline.
// ----------------------------------------------------------------------------
package qslerp_pkg;

    // Number formats.
    localparam int FRAC_BITS    = 14;
    localparam int CORDIC_STEPS = 16;
    localparam int TBL_BITS     = 30;
    localparam int Q_W          = 16;
    localparam int T_W          = 15;
    localparam int ONE          = 1 << FRAC_BITS;

    // Internal widths.
    localparam int CW     = 20;                  // CORDIC x/y datapath
    localparam int ANG_W  = 20;                  // angles, F fraction bits
    localparam int RT_W   = FRAC_BITS + 1;       // square root, up to 2^F
    localparam int RAD_W  = 2 * FRAC_BITS + 1;   // radicand, up to 2^(2F)
    localparam int DOT_W  = 2 * Q_W + 2;         // exact dot product
    localparam int DVD_W  = CW + FRAC_BITS;      // scaled sine dividend
    localparam int COEF_W = FRAC_BITS + 18;      // holds +/- 2^(F+16)
    localparam int PRD_W  = COEF_W + Q_W;

    // Mode thresholds on the dot product (2F fraction bits).
    localparam longint P2   = longint'(1) << (2 * FRAC_BITS);
    localparam longint EPS2 = (P2 / 100000000) * 1001 + ((P2 % 100000000) * 1001) / 100000000;
    localparam logic signed [DOT_W-1:0] ANTI_LIM = DOT_W'(EPS2 - P2);
    localparam logic signed [DOT_W-1:0] LIN_LIM  = DOT_W'(P2 - EPS2);
    localparam logic [DVD_W-1:0]        COEF_LIM = DVD_W'(longint'(1) << (FRAC_BITS + 16));

    // Angle constants, floor values taken from TBL_BITS down to F fraction bits.
    localparam logic signed [ANG_W-1:0] HALF_PI =
        ANG_W'(64'd1686629713 >> (TBL_BITS - FRAC_BITS));
    localparam logic signed [ANG_W-1:0] PI_ANG =
        ANG_W'(64'd3373259426 >> (TBL_BITS - FRAC_BITS));
    localparam logic signed [CW-1:0] GAIN =
        CW'(64'd652032874 >> (TBL_BITS - FRAC_BITS));

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,
        32'd63,        32'd31,        32'd15,        32'd7,
        32'd3,         32'd1,         32'd0,         32'd0
    };

    // Arctangent of 2^-i in the angle format.
    function automatic logic signed [ANG_W-1:0] atan_at(input logic [4:0] i);
        return ANG_W'(ATAN_TAB[i] >> (TBL_BITS - FRAC_BITS));
    endfunction

    typedef enum logic [1:0] {
        MODE_LINEAR = 2'd0,
        MODE_ANTI   = 2'd1,
        MODE_SLERP  = 2'd2
    } mode_t;

    // Data that rides along the whole pipeline.
    typedef struct packed {
        logic [3:0][Q_W-1:0] qa;
        logic [3:0][Q_W-1:0] qb;
        logic [T_W-1:0]      t;
        mode_t               mode;
    } side_t;

    typedef struct packed {
        logic  valid;
        side_t side;
    } pipe_t;

endpackage

// ----- rtl/qslerp_if.sv -----
// ----------------------------------------------------------------------------
// qslerp_if
// Valid/ready channels for the slerp input and result words.
// ----------------------------------------------------------------------------
interface qslerp_in_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  first_w;
    logic signed [15:0]  first_x;
    logic signed [15:0]  first_y;
    logic signed [15:0]  first_z;
    logic signed [15:0]  second_w;
    logic signed [15:0]  second_x;
    logic signed [15:0]  second_y;
    logic signed [15:0]  second_z;
    logic [14:0]         blend;

    modport source (
        output valid, first_w, first_x, first_y, first_z,
        output second_w, second_x, second_y, second_z, blend,
        input  ready
    );
    modport sink (
        input  valid, first_w, first_x, first_y, first_z,
        input  second_w, second_x, second_y, second_z, blend,
        output ready
    );
endinterface

interface qslerp_out_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  out_w;
    logic signed [15:0]  out_x;
    logic signed [15:0]  out_y;
    logic signed [15:0]  out_z;

    modport source (
        output valid, out_w, out_x, out_y, out_z,
        input  ready
    );
    modport sink (
        input  valid, out_w, out_x, out_y, out_z,
        output ready
    );
endinterface

// ----- rtl/qslerp_isqrt.sv -----
// ----------------------------------------------------------------------------
// qslerp_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qslerp_isqrt (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  qslerp_pkg::pipe_t                    in_pipe,
    input  logic [qslerp_pkg::RAD_W-1:0]         rad,
    input  logic signed [qslerp_pkg::Q_W-1:0]    d_in,
    output qslerp_pkg::pipe_t                    out_pipe,
    output logic [qslerp_pkg::RT_W-1:0]          root,
    output logic signed [qslerp_pkg::Q_W-1:0]    d_out
);

    localparam int N  = qslerp_pkg::RT_W;
    localparam int IW = qslerp_pkg::RAD_W + qslerp_pkg::RT_W + 1;

    qslerp_pkg::pipe_t                  pipe_reg [N];
    logic [qslerp_pkg::RAD_W-1:0]       rem_reg  [N];
    logic [qslerp_pkg::RT_W-1:0]        root_reg [N];
    logic signed [qslerp_pkg::Q_W-1:0]  d_reg    [N];

    genvar k;
    for (k = 0; k < N; k++)
    begin : g_stage
        localparam int B = N - 1 - k;

        qslerp_pkg::pipe_t                  pipe_i;
        logic [qslerp_pkg::RAD_W-1:0]       rem_i;
        logic [qslerp_pkg::RT_W-1:0]        root_i;
        logic signed [qslerp_pkg::Q_W-1:0]  d_i;
        logic [IW-1:0]                      inc;
        logic                               take;

        if (k == 0)
        begin : g_first
            assign pipe_i = in_pipe;
            assign rem_i  = rad;
            assign root_i = '0;
            assign d_i    = d_in;
        end
        else
        begin : g_next
            assign pipe_i = pipe_reg[k-1];
            assign rem_i  = rem_reg[k-1];
            assign root_i = root_reg[k-1];
            assign d_i    = d_reg[k-1];
        end

        // Growth of root^2 when bit B is set: 2*root*2^B + 2^(2B).
        assign inc  = (IW'(root_i) << (B + 1)) | (IW'(1) << (2 * B));
        assign take = IW'(rem_i) >= inc;

        // Valid and side data.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                pipe_reg[k] <= '0;
            else if (en)
                pipe_reg[k] <= pipe_i;
        end

        // Remainder and partial root.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take ? rem_i - inc[qslerp_pkg::RAD_W-1:0] : rem_i;
                root_reg[k] <= take ? (root_i | (qslerp_pkg::RT_W'(1) << B)) : root_i;
                d_reg[k]    <= d_i;
            end
        end
    end

    assign out_pipe = pipe_reg[N-1];
    assign root     = root_reg[N-1];
    assign d_out    = d_reg[N-1];

endmodule

// ----- rtl/qslerp_acos.sv -----
// ----------------------------------------------------------------------------
// qslerp_acos
// Vectoring CORDIC pipeline that turns (d, sqrt(1-d^2)) into acos(d).
// ----------------------------------------------------------------------------
module qslerp_acos (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  qslerp_pkg::pipe_t                     in_pipe,
    input  logic [qslerp_pkg::RT_W-1:0]           root,
    input  logic signed [qslerp_pkg::Q_W-1:0]     d_in,
    output qslerp_pkg::pipe_t                     out_pipe,
    output logic signed [qslerp_pkg::ANG_W-1:0]   theta
);

    localparam int N  = qslerp_pkg::CORDIC_STEPS;
    localparam int CW = qslerp_pkg::CW;
    localparam int AW = qslerp_pkg::ANG_W;

    qslerp_pkg::pipe_t     pipe_reg [N];
    logic signed [CW-1:0]  x_reg    [N];
    logic signed [CW-1:0]  y_reg    [N];
    logic signed [AW-1:0]  z_reg    [N];

    logic signed [CW-1:0]  d_ext;
    logic signed [CW-1:0]  s_ext;
    logic signed [CW-1:0]  x0;
    logic signed [CW-1:0]  y0;
    logic signed [AW-1:0]  z0;

    // A negative d is first turned by -pi/2 so the loop converges.
    assign d_ext = CW'(d_in);
    assign s_ext = CW'(root);
    assign x0    = d_ext[CW-1] ? s_ext : d_ext;
    assign y0    = d_ext[CW-1] ? -d_ext : s_ext;
    assign z0    = d_ext[CW-1] ? qslerp_pkg::HALF_PI : '0;

    genvar k;
    for (k = 0; k < N; k++)
    begin : g_stage
        qslerp_pkg::pipe_t     pipe_i;
        logic signed [CW-1:0]  x_i;
        logic signed [CW-1:0]  y_i;
        logic signed [AW-1:0]  z_i;
        logic signed [AW-1:0]  step;

        if (k == 0)
        begin : g_first
            assign pipe_i = in_pipe;
            assign x_i    = x0;
            assign y_i    = y0;
            assign z_i    = z0;
        end
        else
        begin : g_next
            assign pipe_i = pipe_reg[k-1];
            assign x_i    = x_reg[k-1];
            assign y_i    = y_reg[k-1];
            assign z_i    = z_reg[k-1];
        end

        assign step = qslerp_pkg::atan_at(5'(k));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                pipe_reg[k] <= '0;
            else if (en)
                pipe_reg[k] <= pipe_i;
        end

        // Rotate toward the x axis and accumulate the angle.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_i[CW-1])
                begin
                    x_reg[k] <= x_i + (y_i >>> k);
                    y_reg[k] <= y_i - (x_i >>> k);
                    z_reg[k] <= z_i + step;
                end
                else
                begin
                    x_reg[k] <= x_i - (y_i >>> k);
                    y_reg[k] <= y_i + (x_i >>> k);
                    z_reg[k] <= z_i - step;
                end
            end
        end
    end

    assign out_pipe = pipe_reg[N-1];
    assign theta    = z_reg[N-1];

endmodule

// ----- rtl/qslerp_sin.sv -----
// ----------------------------------------------------------------------------
// qslerp_sin
// Three-lane rotation CORDIC pipeline giving the sine of three angles.
// ----------------------------------------------------------------------------
module qslerp_sin (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  qslerp_pkg::pipe_t                           in_pipe,
    input  logic [2:0][qslerp_pkg::ANG_W-1:0]           ang,
    output qslerp_pkg::pipe_t                           out_pipe,
    output logic [2:0][qslerp_pkg::CW-1:0]              sine
);

    localparam int N  = qslerp_pkg::CORDIC_STEPS;
    localparam int CW = qslerp_pkg::CW;
    localparam int AW = qslerp_pkg::ANG_W;

    qslerp_pkg::pipe_t     pipe_reg [N];
    logic [2:0][CW-1:0]    x_reg    [N];
    logic [2:0][CW-1:0]    y_reg    [N];
    logic [2:0][AW-1:0]    z_reg    [N];

    logic [2:0][AW-1:0]    z0;

    // Angles past pi/2 are folded back with sin(pi - a) = sin(a).
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if ($signed(ang[l]) > qslerp_pkg::HALF_PI)
                z0[l] = qslerp_pkg::PI_ANG - $signed(ang[l]);
            else
                z0[l] = ang[l];
        end
    end

    genvar k;
    for (k = 0; k < N; k++)
    begin : g_stage
        qslerp_pkg::pipe_t     pipe_i;
        logic [2:0][CW-1:0]    x_i;
        logic [2:0][CW-1:0]    y_i;
        logic [2:0][AW-1:0]    z_i;
        logic [2:0][CW-1:0]    x_n;
        logic [2:0][CW-1:0]    y_n;
        logic [2:0][AW-1:0]    z_n;
        logic signed [AW-1:0]  step;

        if (k == 0)
        begin : g_first
            assign pipe_i = in_pipe;
            assign x_i    = {3{qslerp_pkg::GAIN}};
            assign y_i    = '0;
            assign z_i    = z0;
        end
        else
        begin : g_next
            assign pipe_i = pipe_reg[k-1];
            assign x_i    = x_reg[k-1];
            assign y_i    = y_reg[k-1];
            assign z_i    = z_reg[k-1];
        end

        assign step = qslerp_pkg::atan_at(5'(k));

        // One micro-rotation per lane, driven by the residual angle sign.
        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (!z_i[l][AW-1])
                begin
                    x_n[l] = $signed(x_i[l]) - ($signed(y_i[l]) >>> k);
                    y_n[l] = $signed(y_i[l]) + ($signed(x_i[l]) >>> k);
                    z_n[l] = $signed(z_i[l]) - step;
                end
                else
                begin
                    x_n[l] = $signed(x_i[l]) + ($signed(y_i[l]) >>> k);
                    y_n[l] = $signed(y_i[l]) - ($signed(x_i[l]) >>> k);
                    z_n[l] = $signed(z_i[l]) + step;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                pipe_reg[k] <= '0;
            else if (en)
                pipe_reg[k] <= pipe_i;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k] <= x_n;
                y_reg[k] <= y_n;
                z_reg[k] <= z_n;
            end
        end
    end

    assign out_pipe = pipe_reg[N-1];
    assign sine     = y_reg[N-1];

endmodule

// ----- rtl/qslerp_div.sv -----
// ----------------------------------------------------------------------------
// qslerp_div
// Two-lane pipelined restoring divider for sin(part) * 2^F / sin(theta).
// ----------------------------------------------------------------------------
module qslerp_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  qslerp_pkg::pipe_t                      in_pipe,
    input  logic [1:0][qslerp_pkg::CW-1:0]         num,
    input  logic [qslerp_pkg::CW-1:0]              den,
    output qslerp_pkg::pipe_t                      out_pipe,
    output logic [1:0][qslerp_pkg::DVD_W-1:0]      quo,
    output logic [1:0]                             neg
);

    localparam int N  = qslerp_pkg::DVD_W;
    localparam int CW = qslerp_pkg::CW;

    qslerp_pkg::pipe_t     pipe_reg [N];
    logic [1:0][CW-1:0]    rem_reg  [N];
    logic [1:0][N-1:0]     dvd_reg  [N];
    logic [1:0]            neg_reg  [N];
    logic [CW-1:0]         den_reg  [N];

    logic [1:0][N-1:0]     dvd0;
    logic [1:0]            neg0;

    // Divide magnitudes; the quotient sign is put back afterwards.
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            neg0[l] = num[l][CW-1];
            dvd0[l] = {(num[l][CW-1] ? -num[l] : num[l]), {qslerp_pkg::FRAC_BITS{1'b0}}};
        end
    end

    genvar k;
    for (k = 0; k < N; k++)
    begin : g_stage
        qslerp_pkg::pipe_t     pipe_i;
        logic [1:0][CW-1:0]    rem_i;
        logic [1:0][N-1:0]     dvd_i;
        logic [1:0]            neg_i;
        logic [CW-1:0]         den_i;
        logic [1:0][CW:0]      rw;
        logic [1:0][CW:0]      diff;
        logic [1:0]            ge;
        logic [1:0][CW-1:0]    rem_n;
        logic [1:0][N-1:0]     dvd_n;

        if (k == 0)
        begin : g_first
            assign pipe_i = in_pipe;
            assign rem_i  = '0;
            assign dvd_i  = dvd0;
            assign neg_i  = neg0;
            assign den_i  = den;
        end
        else
        begin : g_next
            assign pipe_i = pipe_reg[k-1];
            assign rem_i  = rem_reg[k-1];
            assign dvd_i  = dvd_reg[k-1];
            assign neg_i  = neg_reg[k-1];
            assign den_i  = den_reg[k-1];
        end

        // Bring in the next dividend bit and try a subtract.
        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                rw[l]    = {rem_i[l], dvd_i[l][N-1]};
                diff[l]  = rw[l] - {1'b0, den_i};
                ge[l]    = rw[l] >= {1'b0, den_i};
                rem_n[l] = ge[l] ? diff[l][CW-1:0] : rw[l][CW-1:0];
                dvd_n[l] = {dvd_i[l][N-2:0], ge[l]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                pipe_reg[k] <= '0;
            else if (en)
                pipe_reg[k] <= pipe_i;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_n;
                dvd_reg[k] <= dvd_n;
                neg_reg[k] <= neg_i;
                den_reg[k] <= den_i;
            end
        end
    end

    assign out_pipe = pipe_reg[N-1];
    assign quo      = dvd_reg[N-1];
    assign neg      = neg_reg[N-1];

endmodule

// ----- rtl/quaternion_slerp_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_slerp_unit
// Fixed-point quaternion slerp: dot product, acos and sine by CORDIC,
// coefficient division and a saturated blend, fully pipelined.
// ----------------------------------------------------------------------------
//  Channel  Direction  Word
//  feed     in         first_w..z, second_w..z (Q2.14), blend (unsigned Q1.14)
//  result   out        out_w..z (Q2.14, saturated)
//
//  One word is taken per cycle while feed.ready is high.
//  The pipeline runs through the square root, two CORDICs and the 34-stage divider.
//  Reset clears all valid bits, those of the output buffers included, and the side data riding with them.
//  A stalled result is held in the output register, one more word in a skid
//  register; feed.ready drops while the skid register is full and the whole
//  pipeline then holds.
// ----------------------------------------------------------------------------
module quaternion_slerp_unit (
    input  logic               clk,
    input  logic               rst_n,
    qslerp_in_if.sink          feed,
    qslerp_out_if.source       result
);

    localparam int Q_W   = qslerp_pkg::Q_W;
    localparam int F     = qslerp_pkg::FRAC_BITS;
    localparam int DOT_W = qslerp_pkg::DOT_W;
    localparam int AW    = qslerp_pkg::ANG_W;
    localparam int CW    = qslerp_pkg::CW;
    localparam int COW   = qslerp_pkg::COEF_W;
    localparam int PW    = qslerp_pkg::PRD_W;
    localparam int T_W   = qslerp_pkg::T_W;

    logic en;

    // Stage 1: capture and component products.
    qslerp_pkg::pipe_t          in_pipe;
    qslerp_pkg::pipe_t          p1_reg;
    logic [3:0][2*Q_W-1:0]      prod_reg;
    logic [3:0][2*Q_W-1:0]      prod_next;

    always_comb
    begin
        in_pipe.valid        = feed.valid;
        in_pipe.side.qa      = {feed.first_z, feed.first_y, feed.first_x, feed.first_w};
        in_pipe.side.qb      = {feed.second_z, feed.second_y, feed.second_x, feed.second_w};
        in_pipe.side.t       = (feed.blend > T_W'(qslerp_pkg::ONE)) ?
                               T_W'(qslerp_pkg::ONE) : feed.blend;
        in_pipe.side.mode    = qslerp_pkg::MODE_LINEAR;
        for (int i = 0; i < 4; i++)
            prod_next[i] = $signed(in_pipe.side.qa[i]) * $signed(in_pipe.side.qb[i]);
    end

    // Stage 2: dot product.
    qslerp_pkg::pipe_t          p2_reg;
    logic signed [DOT_W-1:0]    dot_reg;
    logic signed [DOT_W-1:0]    dot_next;

    always_comb
    begin
        dot_next = '0;
        for (int i = 0; i < 4; i++)
            dot_next = dot_next + DOT_W'($signed(prod_reg[i]));
    end

    // Stage 3: mode select and clamped cosine.
    qslerp_pkg::pipe_t          p3_reg;
    qslerp_pkg::pipe_t          p3_next;
    logic signed [Q_W-1:0]      d3_reg;
    logic signed [Q_W-1:0]      d3_next;
    logic signed [DOT_W-1:0]    dot_sh;

    always_comb
    begin
        p3_next = p2_reg;
        dot_sh  = dot_reg >>> F;
        if (dot_reg < qslerp_pkg::ANTI_LIM)
            p3_next.side.mode = qslerp_pkg::MODE_ANTI;
        else if (dot_reg <= qslerp_pkg::LIN_LIM)
            p3_next.side.mode = qslerp_pkg::MODE_SLERP;
        else
            p3_next.side.mode = qslerp_pkg::MODE_LINEAR;
        if (dot_sh > DOT_W'(qslerp_pkg::ONE))
            d3_next = Q_W'(qslerp_pkg::ONE);
        else if (dot_sh < -DOT_W'(qslerp_pkg::ONE))
            d3_next = -Q_W'(qslerp_pkg::ONE);
        else
            d3_next = dot_sh[Q_W-1:0];
    end

    // Stage 4: radicand 1 - d^2.
    qslerp_pkg::pipe_t               p4_reg;
    logic [qslerp_pkg::RAD_W-1:0]    rad_reg;
    logic signed [Q_W-1:0]           d4_reg;
    logic signed [2*Q_W-1:0]         dsq;
    logic [2*Q_W-1:0]                radw;

    assign dsq  = d3_reg * d3_reg;
    assign radw = (2*Q_W)'(qslerp_pkg::P2) - dsq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
            p2_reg <= '0;
            p3_reg <= '0;
            p4_reg <= '0;
        end
        else if (en)
        begin
            p1_reg <= in_pipe;
            p2_reg <= p1_reg;
            p3_reg <= p3_next;
            p4_reg <= p3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            dot_reg  <= dot_next;
            d3_reg   <= d3_next;
            rad_reg  <= radw[qslerp_pkg::RAD_W-1:0];
            d4_reg   <= d3_reg;
        end
    end

    // Square root and arccosine.
    qslerp_pkg::pipe_t               sq_pipe;
    logic [qslerp_pkg::RT_W-1:0]     sq_root;
    logic signed [Q_W-1:0]           sq_d;
    qslerp_pkg::pipe_t               ac_pipe;
    logic signed [AW-1:0]            theta;

    qslerp_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_pipe  (p4_reg),
        .rad      (rad_reg),
        .d_in     (d4_reg),
        .out_pipe (sq_pipe),
        .root     (sq_root),
        .d_out    (sq_d)
    );

    qslerp_acos u_acos (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_pipe  (sq_pipe),
        .root     (sq_root),
        .d_in     (sq_d),
        .out_pipe (ac_pipe),
        .theta    (theta)
    );

    // Stage 5: partial angles (1-t)theta and t theta.
    qslerp_pkg::pipe_t          p5_reg;
    logic [2:0][AW-1:0]         ang_reg;
    logic [T_W-1:0]             omt;
    logic signed [AW+T_W:0]     pa1;
    logic signed [AW+T_W:0]     pa2;
    logic signed [AW+T_W:0]     sa1;
    logic signed [AW+T_W:0]     sa2;

    assign omt = T_W'(qslerp_pkg::ONE) - ac_pipe.side.t;
    assign pa1 = $signed({1'b0, omt}) * theta;
    assign pa2 = $signed({1'b0, ac_pipe.side.t}) * theta;
    assign sa1 = pa1 >>> F;
    assign sa2 = pa2 >>> F;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p5_reg <= '0;
        else if (en)
            p5_reg <= ac_pipe;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ang_reg <= {sa2[AW-1:0], sa1[AW-1:0], theta};
    end

    // Sines of theta and of both partial angles.
    qslerp_pkg::pipe_t          sn_pipe;
    logic [2:0][CW-1:0]         sines;

    qslerp_sin u_sin (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_pipe  (p5_reg),
        .ang      (ang_reg),
        .out_pipe (sn_pipe),
        .sine     (sines)
    );

    // A non-positive sin(theta) falls back to the linear blend.
    qslerp_pkg::pipe_t          dv_in_pipe;

    always_comb
    begin
        dv_in_pipe = sn_pipe;
        if (sn_pipe.side.mode == qslerp_pkg::MODE_SLERP && $signed(sines[0]) <= 0)
            dv_in_pipe.side.mode = qslerp_pkg::MODE_LINEAR;
    end

    qslerp_pkg::pipe_t                  dv_pipe;
    logic [1:0][qslerp_pkg::DVD_W-1:0]  quo;
    logic [1:0]                         qneg;

    qslerp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_pipe  (dv_in_pipe),
        .num      ({sines[2], sines[1]}),
        .den      (sines[0]),
        .out_pipe (dv_pipe),
        .quo      (quo),
        .neg      (qneg)
    );

    // Stage 7: coefficients for the chosen mode.
    qslerp_pkg::pipe_t          p7_reg;
    logic [1:0][COW-1:0]        coef_reg;
    logic [1:0][COW-1:0]        coef_next;
    logic [1:0][COW-1:0]        slerp_c;
    logic [COW-1:0]             t_ext;

    always_comb
    begin
        t_ext = COW'(dv_pipe.side.t);
        for (int l = 0; l < 2; l++)
        begin
            slerp_c[l] = (quo[l] > qslerp_pkg::COEF_LIM) ?
                         qslerp_pkg::COEF_LIM[COW-1:0] : quo[l][COW-1:0];
            if (qneg[l])
                slerp_c[l] = -slerp_c[l];
        end
        unique case (dv_pipe.side.mode)
            qslerp_pkg::MODE_SLERP:
            begin
                coef_next = slerp_c;
            end
            qslerp_pkg::MODE_ANTI:
            begin
                coef_next[0] = COW'(qslerp_pkg::ONE) - t_ext;
                coef_next[1] = -t_ext;
            end
            default:
            begin
                coef_next[0] = COW'(qslerp_pkg::ONE) - t_ext;
                coef_next[1] = t_ext;
            end
        endcase
    end

    // Stage 8: coefficient times component.
    qslerp_pkg::pipe_t          p8_reg;
    logic [3:0][PW-1:0]         ma_reg;
    logic [3:0][PW-1:0]         mb_reg;
    logic [3:0][PW-1:0]         ma_next;
    logic [3:0][PW-1:0]         mb_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            ma_next[i] = $signed(coef_reg[0]) * $signed(p7_reg.side.qa[i]);
            mb_next[i] = $signed(coef_reg[1]) * $signed(p7_reg.side.qb[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p7_reg <= '0;
            p8_reg <= '0;
        end
        else if (en)
        begin
            p7_reg <= dv_pipe;
            p8_reg <= p7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_reg <= coef_next;
            ma_reg   <= ma_next;
            mb_reg   <= mb_next;
        end
    end

    // Sum, scale back and saturate each component.
    logic [3:0][Q_W-1:0]        word;
    logic signed [PW:0]         acc   [4];
    logic signed [PW:0]         acc_s [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            acc[i]   = (PW+1)'($signed(ma_reg[i])) + (PW+1)'($signed(mb_reg[i]));
            acc_s[i] = acc[i] >>> F;
            if (acc_s[i] > (PW+1)'(32767))
                word[i] = 16'h7fff;
            else if (acc_s[i] < -(PW+1)'(32768))
                word[i] = 16'h8000;
            else
                word[i] = acc_s[i][Q_W-1:0];
        end
    end

    // Output register with one skid word behind it.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [3:0][Q_W-1:0]    out_data_reg;
    logic [3:0][Q_W-1:0]    out_data_next;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;
    logic [3:0][Q_W-1:0]    skid_data_reg;
    logic [3:0][Q_W-1:0]    skid_data_next;
    logic                   emit;

    assign en   = !skid_valid_reg;
    assign emit = p8_reg.valid && en;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || result.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = emit;
                out_data_next  = word;
            end
        end
        else if (emit)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign feed.ready   = en;
    assign result.valid = out_valid_reg;
    assign result.out_w = out_data_reg[0];
    assign result.out_x = out_data_reg[1];
    assign result.out_y = out_data_reg[2];
    assign result.out_z = out_data_reg[3];

endmodule

// ----- rtl/qslerp_checker.sv -----
// ----------------------------------------------------------------------------
// qslerp_checker
// Port-level checks of the slerp unit's output buffering, bound to the top.
// ----------------------------------------------------------------------------
module qslerp_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input logic [15:0]  out_w,
    input logic [15:0]  out_x,
    input logic [15:0]  out_y,
    input logic [15:0]  out_z
);

    // A word that is not taken stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_w) && $stable(out_x)
            && $stable(out_y) && $stable(out_z))
        else $error("result word changed while stalled");

    // Input back-pressure only comes from a stalled result.
    a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("feed not ready without a result stall");

    // With the skid word full, a result word is always on show.
    a_bp_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("feed not ready while no result is shown");

    // Taking the word while the skid is full moves the skid word out next.
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && out_valid && out_ready |=> out_valid && in_ready)
        else $error("skid word lost after the result was taken");

endmodule

bind quaternion_slerp_unit qslerp_checker u_qslerp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (feed.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_w     (result.out_w),
    .out_x     (result.out_x),
    .out_y     (result.out_y),
    .out_z     (result.out_z)
);

// ----- verif/quaternion_slerp_unit_chk.sv -----
// ----------------------------------------------------------------------------
// quaternion_slerp_unit_chk
// Watches the feed and result channels of the slerp unit, predicts every
// result word from the accepted input word and compares them in order.
// ----------------------------------------------------------------------------
module quaternion_slerp_unit_chk (
    input  logic     clk,
    input  logic     rst_n,
    qslerp_in_if     feed,
    qslerp_out_if    result,
    output int       fail_count,
    output int       pending
);

    typedef struct {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_t;

    quat_t blend_queue[$];
    int    fails = 0;

    localparam longint ONE_L  = longint'(1) << qslerp_pkg::FRAC_BITS;
    localparam longint ONE2_L = longint'(1) << (2 * qslerp_pkg::FRAC_BITS);
    localparam longint EPS_L  =
        ((ONE2_L / 100000000) * 1001) + ((ONE2_L % 100000000) * 1001) / 100000000;
    localparam int TSHIFT = qslerp_pkg::TBL_BITS - qslerp_pkg::FRAC_BITS;

    // Table value in the angle format.
    function automatic longint arctan_step(input int i);
        longint tab[32];
        tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                127, 63, 31, 15, 7, 3, 1, 0, 0};
        return tab[i] >>> TSHIFT;
    endfunction

    function automatic longint int_sqrt(input longint n);
        longint root;
        longint bitv;
        root = 0;
        bitv = longint'(1) << 62;
        while (bitv > n) bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >>> 1) + bitv;
            end
            else
                root = root >>> 1;
            bitv = bitv >>> 2;
        end
        return root;
    endfunction

    function automatic longint arc_cosine(input longint d);
        longint x;
        longint y;
        longint z;
        longint nx;
        longint s;
        if (d > ONE_L) d = ONE_L;
        if (d < -ONE_L) d = -ONE_L;
        s = int_sqrt(ONE_L * ONE_L - d * d);
        if (d < 0)
        begin
            x = s;
            y = -d;
            z = longint'(64'd1686629713 >> TSHIFT);
        end
        else
        begin
            x = d;
            y = s;
            z = 0;
        end
        for (int i = 0; i < qslerp_pkg::CORDIC_STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + arctan_step(i);
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - arctan_step(i);
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint sine_of(input longint ang);
        longint x;
        longint y;
        longint z;
        longint nx;
        x = longint'(64'd652032874 >> TSHIFT);
        y = 0;
        if (ang > longint'(64'd1686629713 >> TSHIFT))
            ang = longint'(64'd3373259426 >> TSHIFT) - ang;
        z = ang;
        for (int i = 0; i < qslerp_pkg::CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - arctan_step(i);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + arctan_step(i);
            end
            x = nx;
        end
        return y;
    endfunction

    function automatic longint clip_coeff(input longint c);
        longint lim;
        lim = longint'(1) << (qslerp_pkg::FRAC_BITS + 16);
        if (c > lim) return lim;
        if (c < -lim) return -lim;
        return c;
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Blend of the two quaternions for one accepted input word.
    function automatic quat_t slerp_of(input longint a[4], input longint b[4],
                                       input longint t_raw);
        longint dot;
        longint t;
        longint ca;
        longint cb;
        longint theta;
        longint sn;
        longint s1;
        longint s2;
        quat_t q;
        longint r[4];
        dot = 0;
        for (int i = 0; i < 4; i++) dot += a[i] * b[i];
        t = (t_raw > ONE_L) ? ONE_L : t_raw;
        ca = ONE_L - t;
        cb = t;
        if (dot < -ONE2_L + EPS_L)
            cb = -t;
        else if (dot <= ONE2_L - EPS_L)
        begin
            theta = arc_cosine(dot >>> qslerp_pkg::FRAC_BITS);
            sn = sine_of(theta);
            if (sn > 0)
            begin
                s1 = sine_of(((ONE_L - t) * theta) >>> qslerp_pkg::FRAC_BITS);
                s2 = sine_of((t * theta) >>> qslerp_pkg::FRAC_BITS);
                ca = clip_coeff((s1 * ONE_L) / sn);
                cb = clip_coeff((s2 * ONE_L) / sn);
            end
        end
        for (int i = 0; i < 4; i++)
            r[i] = (ca * a[i] + cb * b[i]) >>> qslerp_pkg::FRAC_BITS;
        q.w = clip16(r[0]);
        q.x = clip16(r[1]);
        q.y = clip16(r[2]);
        q.z = clip16(r[3]);
        return q;
    endfunction

    task automatic check_field(input string name, input logic signed [15:0] want,
                               input logic signed [15:0] got);
        if (want !== got)
        begin
            fails++;
            $display("%0t: %s expected %0d actual %0d", $realtime, name, want, got);
        end
    endtask

    assign pending    = blend_queue.size();
    assign fail_count = fails;

    // Predict on every accepted feed word, compare on every result word.
    always @(posedge clk)
    begin
        longint a[4];
        longint b[4];
        quat_t want;
        if (rst_n && feed.valid && feed.ready)
        begin
            a = '{feed.first_w, feed.first_x, feed.first_y, feed.first_z};
            b = '{feed.second_w, feed.second_x, feed.second_y, feed.second_z};
            blend_queue.push_back(slerp_of(a, b, longint'(feed.blend)));
        end
        if (rst_n && result.valid && result.ready)
        begin
            if (blend_queue.size() == 0)
            begin
                fails++;
                $display("%0t: result word with none expected, actual %0d %0d %0d %0d",
                         $realtime, result.out_w, result.out_x, result.out_y,
                         result.out_z);
            end
            else
            begin
                want = blend_queue.pop_front();
                check_field("out_w", want.w, result.out_w);
                check_field("out_x", want.x, result.out_x);
                check_field("out_y", want.y, result.out_y);
                check_field("out_z", want.z, result.out_z);
            end
        end
    end

endmodule

// ----- verif/quaternion_slerp_unit_tb.sv -----
// ----------------------------------------------------------------------------
// quaternion_slerp_unit_tb
// Drives directed and random slerp words with random idling on both channels;
// the checker module predicts and compares every result word.
// ----------------------------------------------------------------------------
module quaternion_slerp_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 700;
    localparam int CALM_WORDS     = 100;
    localparam int DRAIN_CYCLES   = 120;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    bit   calm;

    qslerp_in_if  feed ();
    qslerp_out_if result ();

    quaternion_slerp_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed.sink),
        .result (result.source)
    );

    quaternion_slerp_unit_chk chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed       (feed),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side stalls in bursts of random length.
    initial
    begin
        int gap;
        result.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 3);
                result.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                result.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog on cycles with no accepted word.
    always @(posedge clk)
    begin
        if ((feed.valid && feed.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one word and hold it until accepted, with an optional gap first.
    task automatic send_word(input logic [15:0] q[8], input logic [14:0] t);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            feed.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        feed.valid    <= 1'b1;
        feed.first_w  <= q[0];
        feed.first_x  <= q[1];
        feed.first_y  <= q[2];
        feed.first_z  <= q[3];
        feed.second_w <= q[4];
        feed.second_x <= q[5];
        feed.second_y <= q[6];
        feed.second_z <= q[7];
        feed.blend    <= t;
        @(posedge clk);
        while (!feed.ready) @(posedge clk);
    endtask

    // A random unit-ish quaternion pair; kind picks the relation between them.
    task automatic random_word();
        logic [15:0] q[8];
        logic [14:0] t;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 4; i++)
            q[i] = 16'($signed($urandom_range(0, 16384)) - 8192);
        for (int i = 4; i < 8; i++)
        begin
            case (kind)
                0, 1:    q[i] = q[i-4];
                2:       q[i] = -q[i-4];
                3:       q[i] = q[i-4] + 16'($urandom_range(0, 6)) - 16'd3;
                4:       q[i] = 16'($urandom);
                default: q[i] = 16'($signed($urandom_range(0, 16384)) - 8192);
            endcase
        end
        if (kind == 4)
            for (int i = 0; i < 4; i++) q[i] = 16'($urandom);
        if (kind == 0)
        begin
            q[0] = 16'd16384;
            q[4] = 16'($urandom_range(14000, 16384));
            q[1] = 16'd0; q[2] = 16'd0; q[3] = 16'd0;
        end
        t = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
        send_word(q, t);
    endtask

    initial
    begin
        logic [15:0] q[8];
        calm       = 1'b0;
        rst_n      <= 1'b0;
        feed.valid <= 1'b0;
        feed.first_w  <= '0; feed.first_x  <= '0; feed.first_y  <= '0;
        feed.first_z  <= '0; feed.second_w <= '0; feed.second_x <= '0;
        feed.second_y <= '0; feed.second_z <= '0; feed.blend    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identical, antipodal, orthogonal, extremes and blend beyond one.
        q = '{16'd16384, 0, 0, 0, 16'd16384, 0, 0, 0};
        send_word(q, 15'd0);
        send_word(q, 15'd8192);
        send_word(q, 15'd16384);
        q = '{16'd16384, 0, 0, 0, -16'sd16384, 0, 0, 0};
        send_word(q, 15'd4096);
        send_word(q, 15'd16384);
        q = '{16'd16384, 0, 0, 0, 0, 16'd16384, 0, 0};
        send_word(q, 15'd0);
        send_word(q, 15'd8192);
        send_word(q, 15'd16384);
        send_word(q, 15'h7fff);
        send_word(q, 15'd20000);
        q = '{16'd11585, 16'd11585, 0, 0, 16'd11585, 0, 16'd11585, 0};
        send_word(q, 15'd5000);
        q = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
              16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
        send_word(q, 15'd8192);
        q = '{16'h8000, 16'h8000, 16'h8000, 16'h8000,
              16'h8000, 16'h8000, 16'h8000, 16'h8000};
        send_word(q, 15'd8192);
        q = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
              16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
        send_word(q, 15'd3000);
        q = '{16'hffff, 16'h0000, 16'hffff, 16'h0000,
              16'h0000, 16'hffff, 16'h0000, 16'hffff};
        send_word(q, 15'h7fff);
        // Near-parallel pair whose sine of theta is tiny.
        q = '{16'd16384, 0, 0, 0, 16'd16383, 16'd90, 0, 0};
        send_word(q, 15'd8192);
        q = '{16'd16384, 0, 0, 0, 16'd16380, 16'd300, 0, 0};
        send_word(q, 15'd1);
        // Near-antipodal.
        q = '{16'd16384, 0, 0, 0, -16'sd16383, 16'd90, 0, 0};
        send_word(q, 15'd12000);
        q = '{0, 0, 0, 0, 0, 0, 0, 0};
        send_word(q, 15'd8192);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS - CALM_WORDS)
                calm = 1'b1;
            random_word();
        end
        feed.valid <= 1'b0;

        // Drain, then let the pipeline settle.
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/qslerp_pkg.sv
rtl/qslerp_if.sv
rtl/qslerp_isqrt.sv
rtl/qslerp_acos.sv
rtl/qslerp_sin.sv
rtl/qslerp_div.sv
rtl/quaternion_slerp_unit.sv
rtl/qslerp_checker.sv
verif/quaternion_slerp_unit_chk.sv
verif/quaternion_slerp_unit_tb.sv
